/* rtl/core/svm_pkg.sv */
// svm_pkg: types, constants and microcode table of the stereo vu meter agc
// no dependencies; imported by the top level
package svm_pkg;

    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] CFG_NOISE_GATE   = 2'd0;
    localparam logic [1:0] CFG_USER_GAIN    = 2'd1;
    localparam logic [1:0] CFG_RELEASE_STEP = 2'd2;

    localparam logic [7:0]  NOISE_GATE_RESET   = 8'd2;
    localparam logic [8:0]  USER_GAIN_RESET    = 9'd100;
    localparam logic [3:0]  RELEASE_STEP_RESET = 4'd5;

    localparam logic [8:0]  USER_GAIN_MIN = 9'd50;
    localparam logic [8:0]  USER_GAIN_MAX = 9'd300;
    localparam logic [3:0]  RELEASE_MIN   = 4'd1;
    localparam logic [3:0]  RELEASE_MAX   = 4'd10;

    localparam logic [7:0]  AGC_FLOOR     = 8'd48;
    localparam logic [14:0] AGC_NUMERATOR = 15'd19000;
    localparam logic [8:0]  AGC_MIN       = 9'd70;
    localparam logic [8:0]  AGC_MAX       = 9'd350;
    localparam logic [3:0]  DIV_LAST_BIT  = 4'd8;
    localparam logic [7:0]  LEVEL_MAX     = 8'd255;

    // floor(p / 10000) == (p * GAIN_RECIP) >> GAIN_SHIFT for p below 2^25
    localparam logic [24:0] GAIN_RECIP = 25'd27487791;
    localparam int          GAIN_SHIFT = 38;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FRAME,
        OP_CLEAR,
        OP_TICK_LOAD,
        OP_AGC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_GAIN,
        OP_MUL,
        OP_RECIP,
        OP_FOLLOW,
        OP_FINISH
    } op_t;

    typedef logic [3:0] step_t;

    typedef struct packed {
        op_t  op;
        logic lane;
        logic loop;
        logic last;
        logic emit;
    } ucode_t;

    localparam step_t ENTRY_FRAME = 4'd0;
    localparam step_t ENTRY_CLEAR = 4'd1;
    localparam step_t ENTRY_TICK  = 4'd2;
    localparam step_t ENTRY_NONE  = 4'd14;

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        unique case (s)
            4'd0:    w = '{op: OP_FRAME,     lane: 1'b0, loop: 1'b0, last: 1'b1, emit: 1'b0};
            4'd1:    w = '{op: OP_CLEAR,     lane: 1'b0, loop: 1'b0, last: 1'b1, emit: 1'b1};
            4'd2:    w = '{op: OP_TICK_LOAD, lane: 1'b0, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd3:    w = '{op: OP_AGC,       lane: 1'b0, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd4:    w = '{op: OP_DIV_INIT,  lane: 1'b0, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd5:    w = '{op: OP_DIV_STEP,  lane: 1'b0, loop: 1'b1, last: 1'b0, emit: 1'b0};
            4'd6:    w = '{op: OP_GAIN,      lane: 1'b0, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd7:    w = '{op: OP_MUL,       lane: 1'b0, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd8:    w = '{op: OP_RECIP,     lane: 1'b0, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd9:    w = '{op: OP_FOLLOW,    lane: 1'b0, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd10:   w = '{op: OP_MUL,       lane: 1'b1, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd11:   w = '{op: OP_RECIP,     lane: 1'b1, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd12:   w = '{op: OP_FOLLOW,    lane: 1'b1, loop: 1'b0, last: 1'b0, emit: 1'b0};
            4'd13:   w = '{op: OP_FINISH,    lane: 1'b0, loop: 1'b0, last: 1'b1, emit: 1'b1};
            default: w = '{op: OP_NOP,       lane: 1'b0, loop: 1'b0, last: 1'b1, emit: 1'b0};
        endcase
        return w;
    endfunction

    function automatic step_t entry_step(logic [1:0] req);
        step_t s;
        unique case (req)
            REQ_FRAME: s = ENTRY_FRAME;
            REQ_TICK:  s = ENTRY_TICK;
            REQ_CLEAR: s = ENTRY_CLEAR;
            default:   s = ENTRY_NONE;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/svm_sample_reduce.sv */
// svm_sample_reduce: magnitude of one signed sample, clamped and cut to 8 bits
// no dependencies; instantiated twice by the top level
module svm_sample_reduce #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [7:0]             level
);

    logic [SAMPLE_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] clamped;
    logic [SAMPLE_BITS-1:0] doubled;

    always_comb
    begin
        mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
        // most negative code wraps to itself and lands here too
        if (mag[SAMPLE_BITS-1])
        begin
            clamped = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else
        begin
            clamped = mag;
        end
        doubled = {clamped[SAMPLE_BITS-2:0], 1'b0};
        level   = 8'(doubled >> (SAMPLE_BITS - 8));
    end

endmodule

/* rtl/core/stereo_vu_meter_agc_top.sv */
// stereo_vu_meter_agc_top: stereo level meter with automatic gain, microcoded
// depends on svm_pkg and svm_sample_reduce
//
// input channel (in_valid/in_ready) carries req_type, pcm_frame and playing.
// a frame transaction raises the per-channel peaks and gives no result.
// a tick transaction gives one result with both meters and the tick count;
// a clear transaction zeroes meters and peaks and gives one result.
// request code 3 is dropped without a result.
// each transaction runs as a microprogram from a rom, one control word per
// cycle unless a result step stalls; in_ready is high only while no program
// runs. frame, clear and code 3 end on their entry control word; tick loads
// the gated peaks, updates the agc peak and runs a shift and subtract loop
// that divides the agc numerator by the agc base, then scales both lanes.
// results sit in an output register; a new transaction is accepted while it
// waits, and a program reaching its result step holds there until the
// receiver takes the previous result.
// reset: meters, peaks, agc peak and tick count go to zero, the registers
// to their defaults (gate 2, user gain 100, release step 5).
// cfg_we writes cfg_data to register cfg_index at once; index 3 is ignored.
module stereo_vu_meter_agc_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] pcm_frame,
    input  logic        playing,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  meter_left,
    output logic [7:0]  meter_right,
    output logic [31:0] tick_count,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    import svm_pkg::*;

    localparam int WIDE = (2 * SAMPLE_BITS > 32) ? 2 * SAMPLE_BITS : 32;

    logic        busy_reg, busy_next;
    step_t       step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_left_reg, out_left_next;
    logic [7:0]  out_right_reg, out_right_next;
    logic [31:0] out_ticks_reg, out_ticks_next;

    logic [7:0]  gate_reg, gate_next;
    logic [8:0]  user_reg, user_next;
    logic [3:0]  rel_reg, rel_next;

    logic [7:0]  peak_l_reg, peak_l_next;
    logic [7:0]  peak_r_reg, peak_r_next;
    logic [7:0]  agc_peak_reg, agc_peak_next;
    logic [7:0]  level_l_reg, level_l_next;
    logic [7:0]  level_r_reg, level_r_next;
    logic [31:0] ticks_reg, ticks_next;

    logic [31:0] frame_reg, frame_next;
    logic        playing_reg, playing_next;
    logic [7:0]  raw_l_reg, raw_l_next;
    logic [7:0]  raw_r_reg, raw_r_next;
    logic [7:0]  base_reg, base_next;
    logic [14:0] acc_reg, acc_next;
    logic [8:0]  quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [16:0] total_reg, total_next;
    logic [24:0] prod_reg, prod_next;
    logic [11:0] q_reg, q_next;

    ucode_t      ctl;
    logic        stall;
    logic        step_go;

    logic [WIDE-1:0]        frame_wide;
    logic [SAMPLE_BITS-1:0] sample_l;
    logic [SAMPLE_BITS-1:0] sample_r;
    logic [7:0]             red_l;
    logic [7:0]             red_r;

    logic [8:0]  user_eff;
    logic [3:0]  rel_eff;
    logic [7:0]  src_l;
    logic [7:0]  src_r;
    logic [7:0]  gated_l;
    logic [7:0]  gated_r;
    logic [7:0]  instant;
    logic [15:0] trial;
    logic [8:0]  agc_gain;
    logic [7:0]  raw_sel;
    logic [49:0] recip_prod;
    logic [7:0]  target;
    logic [7:0]  meter_sel;
    logic [7:0]  follow_val;

    assign frame_wide = WIDE'(frame_reg);
    assign sample_l   = frame_wide[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign sample_r   = frame_wide[SAMPLE_BITS-1:0];

    svm_sample_reduce #(.SAMPLE_BITS(SAMPLE_BITS)) u_reduce_l (
        .sample (sample_l),
        .level  (red_l)
    );

    svm_sample_reduce #(.SAMPLE_BITS(SAMPLE_BITS)) u_reduce_r (
        .sample (sample_r),
        .level  (red_r)
    );

    assign ctl     = ucode_rom(step_reg);
    assign stall   = ctl.emit && out_valid_reg && !out_ready;
    assign step_go = busy_reg && !stall;

    assign in_ready    = !busy_reg;
    assign out_valid   = out_valid_reg;
    assign meter_left  = out_left_reg;
    assign meter_right = out_right_reg;
    assign tick_count  = out_ticks_reg;

    // datapath operands
    always_comb
    begin
        if (user_reg < USER_GAIN_MIN)
        begin
            user_eff = USER_GAIN_MIN;
        end
        else if (user_reg > USER_GAIN_MAX)
        begin
            user_eff = USER_GAIN_MAX;
        end
        else
        begin
            user_eff = user_reg;
        end

        if (rel_reg < RELEASE_MIN)
        begin
            rel_eff = RELEASE_MIN;
        end
        else if (rel_reg > RELEASE_MAX)
        begin
            rel_eff = RELEASE_MAX;
        end
        else
        begin
            rel_eff = rel_reg;
        end

        src_l   = playing_reg ? peak_l_reg : 8'd0;
        src_r   = playing_reg ? peak_r_reg : 8'd0;
        gated_l = (src_l <= gate_reg) ? 8'd0 : src_l - gate_reg;
        gated_r = (src_r <= gate_reg) ? 8'd0 : src_r - gate_reg;
        instant = (raw_l_reg > raw_r_reg) ? raw_l_reg : raw_r_reg;

        trial = 16'(base_reg) << cnt_reg;

        if (quo_reg < AGC_MIN)
        begin
            agc_gain = AGC_MIN;
        end
        else if (quo_reg > AGC_MAX)
        begin
            agc_gain = AGC_MAX;
        end
        else
        begin
            agc_gain = quo_reg;
        end

        raw_sel    = ctl.lane ? raw_r_reg : raw_l_reg;
        recip_prod = 50'(prod_reg) * 50'(GAIN_RECIP);

        target    = (q_reg > 12'(LEVEL_MAX)) ? LEVEL_MAX : q_reg[7:0];
        meter_sel = ctl.lane ? level_r_reg : level_l_reg;
        if (target >= meter_sel)
        begin
            follow_val = target;
        end
        else if (meter_sel > 8'(rel_eff))
        begin
            follow_val = meter_sel - 8'(rel_eff);
        end
        else
        begin
            follow_val = 8'd0;
        end
    end

    // sequencer and register updates
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_ticks_next = out_ticks_reg;
        gate_next      = gate_reg;
        user_next      = user_reg;
        rel_next       = rel_reg;
        peak_l_next    = peak_l_reg;
        peak_r_next    = peak_r_reg;
        agc_peak_next  = agc_peak_reg;
        level_l_next   = level_l_reg;
        level_r_next   = level_r_reg;
        ticks_next     = ticks_reg;
        frame_next     = frame_reg;
        playing_next   = playing_reg;
        raw_l_next     = raw_l_reg;
        raw_r_next     = raw_r_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        prod_next      = prod_reg;
        q_next         = q_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NOISE_GATE:   gate_next = cfg_data[7:0];
                CFG_USER_GAIN:    user_next = cfg_data;
                CFG_RELEASE_STEP: rel_next  = cfg_data[3:0];
                default:          ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_valid && in_ready)
        begin
            busy_next    = 1'b1;
            step_next    = entry_step(req_type);
            frame_next   = pcm_frame;
            playing_next = playing;
        end

        if (step_go)
        begin
            unique case (ctl.op)
                OP_NOP:
                begin
                end
                OP_FRAME:
                begin
                    if (red_l > peak_l_reg)
                    begin
                        peak_l_next = red_l;
                    end
                    if (red_r > peak_r_reg)
                    begin
                        peak_r_next = red_r;
                    end
                end
                OP_CLEAR:
                begin
                    level_l_next   = 8'd0;
                    level_r_next   = 8'd0;
                    peak_l_next    = 8'd0;
                    peak_r_next    = 8'd0;
                    out_valid_next = 1'b1;
                    out_left_next  = 8'd0;
                    out_right_next = 8'd0;
                    out_ticks_next = ticks_reg;
                end
                OP_TICK_LOAD:
                begin
                    raw_l_next = gated_l;
                    raw_r_next = gated_r;
                    if (playing_reg)
                    begin
                        peak_l_next = 8'd0;
                        peak_r_next = 8'd0;
                    end
                end
                OP_AGC:
                begin
                    if (instant > agc_peak_reg)
                    begin
                        agc_peak_next = instant;
                    end
                    else if (agc_peak_reg > AGC_FLOOR)
                    begin
                        agc_peak_next = agc_peak_reg - 8'd1;
                    end
                end
                OP_DIV_INIT:
                begin
                    acc_next  = AGC_NUMERATOR;
                    quo_next  = 9'd0;
                    cnt_next  = DIV_LAST_BIT;
                    base_next = (agc_peak_reg < AGC_FLOOR) ? AGC_FLOOR : agc_peak_reg;
                end
                OP_DIV_STEP:
                begin
                    if ({1'b0, acc_reg} >= trial)
                    begin
                        acc_next = acc_reg - 15'(trial);
                        quo_next = {quo_reg[7:0], 1'b1};
                    end
                    else
                    begin
                        quo_next = {quo_reg[7:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 4'd1;
                end
                OP_GAIN:
                begin
                    total_next = 17'(user_eff) * 17'(agc_gain);
                end
                OP_MUL:
                begin
                    prod_next = 25'(raw_sel) * 25'(total_reg);
                end
                OP_RECIP:
                begin
                    q_next = 12'(recip_prod >> GAIN_SHIFT);
                end
                OP_FOLLOW:
                begin
                    if (ctl.lane)
                    begin
                        level_r_next = follow_val;
                    end
                    else
                    begin
                        level_l_next = follow_val;
                    end
                end
                OP_FINISH:
                begin
                    ticks_next     = ticks_reg + 32'd1;
                    out_valid_next = 1'b1;
                    out_left_next  = level_l_reg;
                    out_right_next = level_r_reg;
                    out_ticks_next = ticks_reg + 32'd1;
                end
                default:
                begin
                end
            endcase

            priority if (ctl.loop && cnt_reg != 4'd0)
            begin
                step_next = step_reg;
            end
            else if (ctl.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= ENTRY_NONE;
            out_valid_reg <= 1'b0;
            gate_reg      <= NOISE_GATE_RESET;
            user_reg      <= USER_GAIN_RESET;
            rel_reg       <= RELEASE_STEP_RESET;
            peak_l_reg    <= 8'd0;
            peak_r_reg    <= 8'd0;
            agc_peak_reg  <= 8'd0;
            level_l_reg   <= 8'd0;
            level_r_reg   <= 8'd0;
            ticks_reg     <= 32'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            gate_reg      <= gate_next;
            user_reg      <= user_next;
            rel_reg       <= rel_next;
            peak_l_reg    <= peak_l_next;
            peak_r_reg    <= peak_r_next;
            agc_peak_reg  <= agc_peak_next;
            level_l_reg   <= level_l_next;
            level_r_reg   <= level_r_next;
            ticks_reg     <= ticks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_ticks_reg <= out_ticks_next;
        frame_reg     <= frame_next;
        playing_reg   <= playing_next;
        raw_l_reg     <= raw_l_next;
        raw_r_reg     <= raw_r_next;
        base_reg      <= base_next;
        acc_reg       <= acc_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        total_reg     <= total_next;
        prod_reg      <= prod_next;
        q_reg         <= q_next;
    end

`ifndef NO_ASSERTIONS
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && ctl.op == OP_DIV_STEP |-> cnt_reg <= DIV_LAST_BIT)
        else $error("division loop count out of range");

    a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && ctl.op == OP_DIV_STEP && cnt_reg == 4'd0
        |=> quo_reg >= 9'd74 && quo_reg <= 9'd395)
        else $error("agc quotient out of range");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && ctl.op == OP_GAIN |=> total_reg >= 17'd3500 && total_reg <= 17'd105000)
        else $error("total gain out of range");

    a_tick_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ticks_reg != $past(ticks_reg) |-> out_valid_reg && out_ticks_reg == ticks_reg)
        else $error("tick count advanced without a result");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !ctl.last |=> busy_reg)
        else $error("program ended before its last step");
`endif

endmodule
